### src/speed_pulse_spike_filter_macros.svh
// Assertion macros for the speed pulse spike filter.
// Each macro takes a label, a condition and a consequence, clocked on clk
// and disabled while rst is high.
`ifndef SPEED_PULSE_SPIKE_FILTER_MACROS_SVH
`define SPEED_PULSE_SPIKE_FILTER_MACROS_SVH
`ifndef SYNTH
// consequence holds in the same cycle
`define SPSF_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("spsf assertion failed");
// consequence holds in the next cycle
`define SPSF_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("spsf assertion failed");
`else
`define SPSF_ASSERT_IMP(name, pre, post)
`define SPSF_ASSERT_NXT(name, pre, post)
`endif
`endif

### src/spsf_pkg.sv
`timescale 1ns / 1ps

package spsf_pkg;

  // default widths of stored time and frequency
  localparam int TIME_BITS_DEF = 32;
  localparam int FREQ_BITS_DEF = 24;

  // fixed field widths
  localparam int NOW_BITS      = 32;
  localparam int RAW_BITS      = 24;
  localparam int RATIO_BITS    = 16;
  localparam int PPK_BITS      = 20;
  localparam int SPEED_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RATIO     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PULSES_PER_KM = 2'd2;

  // arithmetic constants
  localparam logic [63:0] SPIKE_LIMIT      = 64'd256000000000;
  localparam int          SPIKE_LIMIT_BITS = 38;
  localparam logic [63:0] MHZ_PER_US_INV   = 64'd1000000000;
  localparam int          DIV_Q_BITS       = 30;
  localparam int          SPD_Q_BITS       = 16;
  localparam int          SPEED_SCALE      = 360;
  localparam int          SCALE_BITS       = 9;
  localparam logic [RATIO_BITS-1:0] RATIO_MIN_Q8      = 16'd282;
  localparam logic [RATIO_BITS-1:0] RATIO_FALLBACK_Q8 = 16'd768;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX         = 16'hFFFF;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP     = 4'd0;
  localparam op_t OP_ELAPSED = 4'd1;
  localparam op_t OP_MULFR   = 4'd2;
  localparam op_t OP_MAC     = 4'd3;
  localparam op_t OP_DIVINIT = 4'd4;
  localparam op_t OP_DIV     = 4'd5;
  localparam op_t OP_QFREQ   = 4'd6;
  localparam op_t OP_RAWFREQ = 4'd7;
  localparam op_t OP_COMMIT  = 4'd8;
  localparam op_t OP_SPDINIT = 4'd9;
  localparam op_t OP_SPDQ    = 4'd10;
  localparam op_t OP_HOLD    = 4'd11;
  localparam op_t OP_EMIT    = 4'd12;

  // loop counter loads
  typedef logic [1:0] cnt_sel_t;
  localparam cnt_sel_t CNT_KEEP = 2'd0;
  localparam cnt_sel_t CNT_TIME = 2'd1;
  localparam cnt_sel_t CNT_DIVQ = 2'd2;
  localparam cnt_sel_t CNT_SPDQ = 2'd3;

  // branch conditions
  typedef logic [2:0] cond_t;
  localparam cond_t BR_NEXT  = 3'd0;
  localparam cond_t BR_JUMP  = 3'd1;
  localparam cond_t BR_CNT   = 3'd2;
  localparam cond_t BR_RAW   = 3'd3;
  localparam cond_t BR_SPIKE = 3'd4;
  localparam cond_t BR_PPK0  = 3'd5;
  localparam cond_t BR_SAT   = 3'd6;
  localparam cond_t BR_DONE  = 3'd7;

  // program addresses
  localparam int UA_BITS = 4;
  typedef logic [UA_BITS-1:0] uaddr_t;
  localparam uaddr_t UA_ELAPSED = 4'd0;
  localparam uaddr_t UA_MULFR   = 4'd1;
  localparam uaddr_t UA_MAC     = 4'd2;
  localparam uaddr_t UA_DIVINIT = 4'd3;
  localparam uaddr_t UA_DIV     = 4'd4;
  localparam uaddr_t UA_QFREQ   = 4'd5;
  localparam uaddr_t UA_RAWFREQ = 4'd6;
  localparam uaddr_t UA_COMMIT  = 4'd7;
  localparam uaddr_t UA_SPDINIT = 4'd8;
  localparam uaddr_t UA_SPDDIV  = 4'd9;
  localparam uaddr_t UA_SPDQ    = 4'd10;
  localparam uaddr_t UA_HOLD    = 4'd11;
  localparam uaddr_t UA_EMIT    = 4'd12;

  typedef struct packed {
    op_t      op;
    cnt_sel_t cnt_sel;
    cond_t    cond;
    uaddr_t   target;
  } ucw_t;

  // sequencer to datapath
  typedef struct packed {
    op_t op;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic raw_path;
    logic spike;
    logic ppk_zero;
    logic spd_sat;
    logic out_free;
  } status_t;

  // control program
  function automatic ucw_t ucode(input uaddr_t addr);
    ucw_t cw;
    unique case (addr)
      UA_ELAPSED: cw = '{OP_ELAPSED, CNT_KEEP, BR_RAW,   UA_RAWFREQ};
      UA_MULFR:   cw = '{OP_MULFR,   CNT_TIME, BR_NEXT,  UA_MAC};
      UA_MAC:     cw = '{OP_MAC,     CNT_KEEP, BR_CNT,   UA_MAC};
      UA_DIVINIT: cw = '{OP_DIVINIT, CNT_DIVQ, BR_SPIKE, UA_EMIT};
      UA_DIV:     cw = '{OP_DIV,     CNT_KEEP, BR_CNT,   UA_DIV};
      UA_QFREQ:   cw = '{OP_QFREQ,   CNT_KEEP, BR_JUMP,  UA_COMMIT};
      UA_RAWFREQ: cw = '{OP_RAWFREQ, CNT_KEEP, BR_NEXT,  UA_COMMIT};
      UA_COMMIT:  cw = '{OP_COMMIT,  CNT_KEEP, BR_PPK0,  UA_EMIT};
      UA_SPDINIT: cw = '{OP_SPDINIT, CNT_SPDQ, BR_SAT,   UA_HOLD};
      UA_SPDDIV:  cw = '{OP_DIV,     CNT_KEEP, BR_CNT,   UA_SPDDIV};
      UA_SPDQ:    cw = '{OP_SPDQ,    CNT_KEEP, BR_NEXT,  UA_HOLD};
      UA_HOLD:    cw = '{OP_HOLD,    CNT_KEEP, BR_NEXT,  UA_EMIT};
      UA_EMIT:    cw = '{OP_EMIT,    CNT_KEEP, BR_DONE,  UA_EMIT};
      default:    cw = '{OP_NOP,     CNT_KEEP, BR_JUMP,  UA_EMIT};
    endcase
    return cw;
  endfunction

endpackage

### src/spsf_seq.sv
`timescale 1ns / 1ps

module spsf_seq #(
  parameter int TIME_BITS = spsf_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  spsf_pkg::status_t  status,
  output spsf_pkg::ctrl_t    ctrl,
  output logic               busy
);

  `include "speed_pulse_spike_filter_macros.svh"

  localparam int SW = (TIME_BITS > spsf_pkg::DIV_Q_BITS) ? TIME_BITS : spsf_pkg::DIV_Q_BITS;
  localparam int CW = $clog2(SW);

  spsf_pkg::uaddr_t pc, pc_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic             busy_next;
  spsf_pkg::ucw_t   cw;

  // control word fetch
  always_comb cw = spsf_pkg::ucode(pc);

  assign ctrl.op = busy ? cw.op : spsf_pkg::OP_NOP;

  // next step and loop count
  always_comb begin
    pc_next   = pc + 1'b1;
    cnt_next  = cnt;
    busy_next = busy;
    unique case (cw.cnt_sel)
      spsf_pkg::CNT_TIME: cnt_next = CW'(TIME_BITS - 1);
      spsf_pkg::CNT_DIVQ: cnt_next = CW'(spsf_pkg::DIV_Q_BITS - 1);
      spsf_pkg::CNT_SPDQ: cnt_next = CW'(spsf_pkg::SPD_Q_BITS - 1);
      default: begin
        if (cw.cond == spsf_pkg::BR_CNT && cnt != '0) cnt_next = cnt - 1'b1;
      end
    endcase
    unique case (cw.cond)
      spsf_pkg::BR_JUMP:  pc_next = cw.target;
      spsf_pkg::BR_CNT:   if (cnt != '0) pc_next = cw.target;
      spsf_pkg::BR_RAW:   if (status.raw_path) pc_next = cw.target;
      spsf_pkg::BR_SPIKE: if (status.spike) pc_next = cw.target;
      spsf_pkg::BR_PPK0:  if (status.ppk_zero) pc_next = cw.target;
      spsf_pkg::BR_SAT:   if (status.spd_sat) pc_next = cw.target;
      spsf_pkg::BR_DONE: begin
        if (status.out_free) busy_next = 1'b0;
        else pc_next = pc;
      end
      default: ;
    endcase
  end

  // step counter, loop counter, busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= spsf_pkg::UA_ELAPSED;
      cnt  <= '0;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        pc   <= spsf_pkg::UA_ELAPSED;
      end
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
      cnt  <= cnt_next;
    end
  end

  `SPSF_ASSERT_NXT(a_start_at_top, !busy && in_valid, busy && pc == spsf_pkg::UA_ELAPSED)
  `SPSF_ASSERT_NXT(a_done_frees, busy && cw.cond == spsf_pkg::BR_DONE && status.out_free, !busy)
  `SPSF_ASSERT_NXT(a_loop_exit, busy && cw.cond == spsf_pkg::BR_CNT && cnt == '0, pc == $past(pc) + 4'd1)

endmodule

### src/spsf_dp.sv
`timescale 1ns / 1ps

module spsf_dp #(
  parameter int TIME_BITS = spsf_pkg::TIME_BITS_DEF,
  parameter int FREQ_BITS = spsf_pkg::FREQ_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spsf_pkg::ctrl_t                   ctrl,
  output spsf_pkg::status_t                 status,
  input  logic [spsf_pkg::NOW_BITS-1:0]     item_now,
  input  logic [spsf_pkg::RAW_BITS-1:0]     item_raw,
  input  logic                              filter_enable,
  input  logic [spsf_pkg::RATIO_BITS-1:0]   max_ratio_q8,
  input  logic [spsf_pkg::PPK_BITS-1:0]     pulses_per_km,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [spsf_pkg::SPEED_BITS-1:0]   speed_centikph,
  output logic                              spike_rejected
);

  `include "speed_pulse_spike_filter_macros.svh"

  localparam int MW  = FREQ_BITS + spsf_pkg::RATIO_BITS;
  localparam int SW  = (TIME_BITS > spsf_pkg::DIV_Q_BITS) ? TIME_BITS : spsf_pkg::DIV_Q_BITS;
  localparam int DVW = (TIME_BITS > spsf_pkg::PPK_BITS) ? TIME_BITS : spsf_pkg::PPK_BITS;
  localparam int AW0 = (TIME_BITS > MW) ? TIME_BITS + 1 : MW + 1;
  localparam int AW  = (AW0 > spsf_pkg::SPIKE_LIMIT_BITS + 2) ? AW0
                                                               : spsf_pkg::SPIKE_LIMIT_BITS + 2;
  localparam int NW  = FREQ_BITS + spsf_pkg::SCALE_BITS;
  localparam int QW  = spsf_pkg::SPD_Q_BITS;

  localparam logic [31:0]    FMAX32   = 32'((64'd1 << FREQ_BITS) - 64'd1);
  localparam logic [AW-1:0]  LIMIT    = AW'(spsf_pkg::SPIKE_LIMIT);
  localparam logic [SW-1:0]  DIVIDEND = SW'(spsf_pkg::MHZ_PER_US_INV) << (SW - spsf_pkg::DIV_Q_BITS);

  // stored state
  logic [TIME_BITS-1:0]            last_time;
  logic [FREQ_BITS-1:0]            last_freq;
  logic [spsf_pkg::SPEED_BITS-1:0] held;

  // working registers
  logic [TIME_BITS-1:0]            elapsed;
  logic [MW-1:0]                   fr_prod;
  logic [AW-1:0]                   acc;
  logic [SW-1:0]                   sh;
  logic [DVW-1:0]                  dvs;
  logic [FREQ_BITS-1:0]            freq;
  logic [NW-1:0]                   num;
  logic [spsf_pkg::SPEED_BITS-1:0] spd;
  logic                            spk;

  logic [spsf_pkg::RATIO_BITS-1:0] ratio;
  logic [AW-1:0]                   mac_sum;
  logic [AW-1:0]                   rem;
  logic [AW-1:0]                   rem_sub;
  logic                            rem_ge;
  logic [31:0]                     q32;
  logic [31:0]                     qsat;
  logic [31:0]                     raw32;
  logic [31:0]                     rawsat;
  logic                            out_free;

  // small ratios fall back to 3.0
  assign ratio = (max_ratio_q8 < spsf_pkg::RATIO_MIN_Q8) ? spsf_pkg::RATIO_FALLBACK_Q8
                                                          : max_ratio_q8;

  // shift-add step of elapsed * (freq * ratio), MSB of elapsed first
  assign mac_sum = {acc[AW-2:0], 1'b0} + (sh[SW-1] ? AW'(fr_prod) : '0);

  // restoring divide step
  assign rem     = {acc[AW-2:0], sh[SW-1]};
  assign rem_ge  = rem >= AW'(dvs);
  assign rem_sub = rem - AW'(dvs);

  // frequency saturation
  assign q32    = 32'(sh[spsf_pkg::DIV_Q_BITS-1:0]);
  assign qsat   = (q32 > FMAX32) ? FMAX32 : q32;
  assign raw32  = 32'(item_raw);
  assign rawsat = (raw32 > FMAX32) ? FMAX32 : raw32;

  assign out_free = !out_valid || !out_stall;

  // flags for the sequencer
  assign status.raw_path = !(filter_enable && last_time != '0);
  assign status.spike    = acc < LIMIT;
  assign status.ppk_zero = pulses_per_km == '0;
  assign status.spd_sat  = 64'(num[NW-1:QW]) >= 64'(pulses_per_km);
  assign status.out_free = out_free;

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      last_freq <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (ctrl.op)
        spsf_pkg::OP_COMMIT: begin
          last_time <= TIME_BITS'(item_now);
          last_freq <= freq;
        end
        spsf_pkg::OP_HOLD: held <= spd;
        default: ;
      endcase
      // result valid: set on emit, cleared once taken
      if (ctrl.op == spsf_pkg::OP_EMIT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      spsf_pkg::OP_ELAPSED: elapsed <= TIME_BITS'(item_now) - last_time;
      spsf_pkg::OP_MULFR: begin
        fr_prod <= MW'(last_freq) * MW'(ratio);
        acc     <= '0;
        sh      <= SW'(elapsed) << (SW - TIME_BITS);
      end
      spsf_pkg::OP_MAC: begin
        // once past the limit the sum only grows, so it is held
        if (acc < LIMIT) acc <= mac_sum;
        sh <= sh << 1;
      end
      spsf_pkg::OP_DIVINIT: begin
        spd <= held;
        spk <= 1'b1;
        acc <= '0;
        sh  <= DIVIDEND;
        dvs <= DVW'(elapsed);
      end
      spsf_pkg::OP_DIV: begin
        acc <= rem_ge ? rem_sub : rem;
        sh  <= {sh[SW-2:0], rem_ge};
      end
      spsf_pkg::OP_QFREQ:   freq <= qsat[FREQ_BITS-1:0];
      spsf_pkg::OP_RAWFREQ: freq <= rawsat[FREQ_BITS-1:0];
      spsf_pkg::OP_COMMIT: begin
        num <= NW'(freq) * NW'(spsf_pkg::SPEED_SCALE);
        spd <= '0;
        spk <= 1'b0;
      end
      spsf_pkg::OP_SPDINIT: begin
        // saturated speed unless the divide runs
        spd <= spsf_pkg::SPEED_MAX;
        acc <= AW'(num[NW-1:QW]);
        sh  <= {num[QW-1:0], {(SW-QW){1'b0}}};
        dvs <= DVW'(pulses_per_km);
      end
      spsf_pkg::OP_SPDQ: spd <= sh[QW-1:0];
      spsf_pkg::OP_EMIT: begin
        if (out_free) begin
          speed_centikph <= spd;
          spike_rejected <= spk;
        end
      end
      default: ;
    endcase
  end

  `SPSF_ASSERT_IMP(a_out_from_emit, $rose(out_valid), $past(ctrl.op) == spsf_pkg::OP_EMIT)
  `SPSF_ASSERT_NXT(a_emit_loads, ctrl.op == spsf_pkg::OP_EMIT && out_free, out_valid)
  `SPSF_ASSERT_IMP(a_held_on_hold, !$past(rst) && $past(ctrl.op) != spsf_pkg::OP_HOLD, $stable(held))

endmodule

### src/speed_pulse_spike_filter.sv
// Each request runs the control program: elapsed time, then on the filtered path a
// bit-serial multiply and spike check and a 30-step restoring divide for frequency
// (the raw path takes the raw frequency); then, unless a spike was rejected or
// pulses_per_km is zero or speed saturates, a 16-step restoring divide for speed.
// One request at a time; a stalled result holds off the next request.
// Synchronous rst restores config defaults and clears all stored state at once.
`timescale 1ns / 1ps

module speed_pulse_spike_filter #(
  parameter int TIME_BITS = spsf_pkg::TIME_BITS_DEF,
  parameter int FREQ_BITS = spsf_pkg::FREQ_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [spsf_pkg::NOW_BITS-1:0]        now_us,
  input  logic [spsf_pkg::RAW_BITS-1:0]        raw_freq_mhz,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [spsf_pkg::SPEED_BITS-1:0]      speed_centikph,
  output logic                                 spike_rejected,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spsf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [spsf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic                              filter_enable;
  logic [spsf_pkg::RATIO_BITS-1:0]   max_ratio_q8;
  logic [spsf_pkg::PPK_BITS-1:0]     pulses_per_km;
  logic [spsf_pkg::NOW_BITS-1:0]     now_hold;
  logic [spsf_pkg::RAW_BITS-1:0]     raw_hold;
  logic                              busy;
  spsf_pkg::ctrl_t                   ctrl;
  spsf_pkg::status_t                 status;

  // nothing is taken while in reset
  assign cfg_ready = !rst;
  assign in_stall  = busy || rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b1;
      max_ratio_q8  <= spsf_pkg::RATIO_FALLBACK_Q8;
      pulses_per_km <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spsf_pkg::CFG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        spsf_pkg::CFG_MAX_RATIO:     max_ratio_q8  <= cfg_data[spsf_pkg::RATIO_BITS-1:0];
        spsf_pkg::CFG_PULSES_PER_KM: pulses_per_km <= cfg_data[spsf_pkg::PPK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      now_hold <= now_us;
      raw_hold <= raw_freq_mhz;
    end
  end

  spsf_seq #(
    .TIME_BITS(TIME_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  spsf_dp #(
    .TIME_BITS(TIME_BITS),
    .FREQ_BITS(FREQ_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .status         (status),
    .item_now       (now_hold),
    .item_raw       (raw_hold),
    .filter_enable  (filter_enable),
    .max_ratio_q8   (max_ratio_q8),
    .pulses_per_km  (pulses_per_km),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .speed_centikph (speed_centikph),
    .spike_rejected (spike_rejected)
  );

endmodule
